>>> rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg: shared types and constants for the button counter display block
// Holds the payload structs, register indexes, reset values and the
// seven segment decode table.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Configuration port, timer and count widths.
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgValW = 16;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CountW  = 7;

  // Reset values and limits.
  localparam logic [TicksW-1:0] DebTicksRst = 16'd40;
  localparam logic [TicksW-1:0] MuxTicksRst = 16'd4;
  localparam logic [CountW-1:0] CountMax    = 7'd99;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounceTicks = 8'd0,
    CfgMuxTicks      = 8'd1
  } cfg_idx_e;

  // One input tick: the three active-low button levels.
  typedef struct packed {
    logic left_button_level;
    logic middle_button_level;
    logic right_button_level;
  } in_item_t;

  // One result per tick.
  typedef struct packed {
    logic [6:0]        segments;
    logic              left_digit_on;
    logic              right_digit_on;
    logic [CountW-1:0] count;
  } out_item_t;

  // Debounced button actions that are due this tick.
  typedef struct packed {
    logic dec;
    logic cmp;
    logic inc;
  } act_t;

  // Next display state, handed to the result register.
  typedef struct packed {
    logic [6:0] segments;
    logic       left_on;
  } disp_t;

  // Segment patterns for digits 0 to 9, bit0 = a .. bit6 = g.
  localparam logic [6:0] SegTable [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

endpackage

>>> rtl/dmc_debounce.sv
// ----------------------------------------------------------------------------
// dmc_debounce: debounce timer for one push button
// A falling edge loads the timer; when it runs out the button is sampled
// and an action is requested if it is still pressed.
// ----------------------------------------------------------------------------
module dmc_debounce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       level_i,
  input  logic [dmc_pkg::TicksW-1:0] ticks_i,
  output logic                       req_o
);
  import dmc_pkg::*;

  logic              prev_q, prev_d;
  logic              armed_q, armed_d;
  logic [TicksW-1:0] cnt_q, cnt_d;
  logic              fall;

  // Edge detection and timer update for this tick.
  always_comb begin
    fall    = prev_q & ~level_i;
    prev_d  = level_i;
    armed_d = armed_q;
    cnt_d   = cnt_q;
    if (fall) begin
      cnt_d   = (ticks_i == '0) ? TicksW'(1) : ticks_i;
      armed_d = 1'b1;
    end else if (armed_q) begin
      cnt_d = cnt_q - TicksW'(1);
      if (cnt_q == TicksW'(1)) begin
        armed_d = 1'b0;
      end
    end
  end

  // The timer expires this tick and the button is still held low.
  assign req_o = armed_q & ~fall & (cnt_q == TicksW'(1)) & ~level_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      armed_q <= 1'b0;
      cnt_q   <= '0;
    end else if (step_i) begin
      prev_q  <= prev_d;
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/dmc_counter.sv
// ----------------------------------------------------------------------------
// dmc_counter: modulo 100 counter
// Applies the due button actions in the order decrement, complement to 99,
// increment.
// ----------------------------------------------------------------------------
module dmc_counter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  dmc_pkg::act_t              act_i,
  output logic [dmc_pkg::CountW-1:0] count_o,
  output logic [dmc_pkg::CountW-1:0] count_d_o
);
  import dmc_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] after_dec, after_cmp;

  // Three short steps on a 7-bit value, one for each button.
  always_comb begin
    after_dec = count_q;
    if (act_i.dec) begin
      after_dec = (count_q == '0) ? CountMax : count_q - CountW'(1);
    end
    after_cmp = after_dec;
    if (act_i.cmp) begin
      after_cmp = CountMax - after_dec;
    end
    count_d = after_cmp;
    if (act_i.inc) begin
      count_d = (after_cmp >= CountMax) ? '0 : after_cmp + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  assign count_o   = count_q;
  assign count_d_o = count_d;

endmodule

>>> rtl/dmc_display.sv
// ----------------------------------------------------------------------------
// dmc_display: two digit display multiplexer
// Counts down the mux period and, when it runs out, swaps the active digit
// and latches the segment pattern of the digit it now shows.
// ----------------------------------------------------------------------------
module dmc_display (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [dmc_pkg::TicksW-1:0] mux_ticks_i,
  input  logic [dmc_pkg::CountW-1:0] count_i,
  output dmc_pkg::disp_t             disp_d_o
);
  import dmc_pkg::*;

  logic [TicksW-1:0] cnt_q, cnt_d;
  logic              left_q, left_d;
  logic [6:0]        seg_q, seg_d;
  logic [14:0]       prod;
  logic [3:0]        tens;
  logic [3:0]        units;
  logic [CountW-1:0] tens_x10;

  // Digit split: tens = count * 205 / 2048 is exact for every 7-bit count, 0 to 127.
  always_comb begin
    prod     = 15'(count_i) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = {tens, 3'b000} - 7'd0 + {2'b00, tens, 1'b0};
    units    = 4'(count_i - tens_x10);
  end

  // Period countdown and digit swap.
  always_comb begin
    cnt_d  = cnt_q - TicksW'(1);
    left_d = left_q;
    seg_d  = seg_q;
    if (cnt_q <= TicksW'(1)) begin
      cnt_d = (mux_ticks_i == '0) ? TicksW'(1) : mux_ticks_i;
      if (left_q) begin
        left_d = 1'b0;
        seg_d  = SegTable[units];
      end else begin
        left_d = 1'b1;
        seg_d  = SegTable[tens];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= MuxTicksRst;
      left_q <= 1'b1;
      seg_q  <= '0;
    end else if (step_i) begin
      cnt_q  <= cnt_d;
      left_q <= left_d;
      seg_q  <= seg_d;
    end
  end

  assign disp_d_o.segments = seg_d;
  assign disp_d_o.left_on  = left_d;

endmodule

>>> rtl/debounced_mod100_counter_7seg_mux.sv
// ----------------------------------------------------------------------------
// debounced_mod100_counter_7seg_mux: debounced up/down counter with display
// Three debounced buttons drive a 0..99 counter shown on a multiplexed
// two digit seven segment display, one tick per input transaction.
//
//   Channel   Dir  Handshake            Payload
//   in        in   in_valid_i/ready_o   in_data_i   (in_item_t)
//   out       out  out_valid_o/ready_i  out_data_o  (out_item_t)
//   cfg       in   cfg_valid_i/ready_o  cfg_index_i, cfg_value_i
//
// A tick is taken into the input register, processed in one pass and its
// result written to the result register; one tick is accepted every cycle
// when the output side keeps up.
// The input register refills in the cycle its tick moves on, so only a stall
// of the output side holds the input back.
// Reset clears the counter, selects the left digit and loads the register
// defaults; no clearing pass. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module debounced_mod100_counter_7seg_mux (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dmc_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dmc_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dmc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dmc_pkg::CfgValW-1:0] cfg_value_i
);
  import dmc_pkg::*;

  logic              s0_valid_q;
  in_item_t          s0_data_q;
  logic              out_valid_q;
  out_item_t         out_q, out_d;
  logic              adv;
  logic [TicksW-1:0] deb_ticks_q, mux_ticks_q;
  logic [2:0]        levels;
  logic [2:0]        req;
  act_t              act;
  logic [CountW-1:0] count_cur, count_nxt;
  disp_t             disp_nxt;

  // Pipeline control: the input register advances when the result slot is
  // free or being emptied this cycle.
  assign adv         = s0_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~s0_valid_q | adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q <= DebTicksRst;
      mux_ticks_q <= MuxTicksRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDebounceTicks: deb_ticks_q <= TicksW'(cfg_value_i);
        CfgMuxTicks:      mux_ticks_q <= TicksW'(cfg_value_i);
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_data_q <= in_data_i;
    end
  end

  // Button debouncers: left, middle, right.
  assign levels = {s0_data_q.left_button_level, s0_data_q.middle_button_level,
                   s0_data_q.right_button_level};

  for (genvar b = 0; b < 3; b++) begin : g_btn
    dmc_debounce u_debounce (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (adv),
      .level_i (levels[b]),
      .ticks_i (deb_ticks_q),
      .req_o   (req[b])
    );
  end

  assign act.dec = req[2];
  assign act.cmp = req[1];
  assign act.inc = req[0];

  dmc_counter u_counter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .act_i     (act),
    .count_o   (count_cur),
    .count_d_o (count_nxt)
  );

  // The display sees the count from before this tick's actions.
  dmc_display u_display (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .mux_ticks_i (mux_ticks_q),
    .count_i     (count_cur),
    .disp_d_o    (disp_nxt)
  );

  // Result register.
  always_comb begin
    out_d.segments       = disp_nxt.segments;
    out_d.left_digit_on  = disp_nxt.left_on;
    out_d.right_digit_on = ~disp_nxt.left_on;
    out_d.count          = count_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // Checks on the pipeline and the result contents.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.count <= CountMax))
    else $error("count left the range 0 to 99");

  a_digit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.left_digit_on != out_q.right_digit_on))
    else $error("both or neither digit enabled");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced transaction produced no result");

  a_s0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !adv) |=> (s0_valid_q && $stable(s0_data_q)))
    else $error("stalled input transaction lost");

endmodule
